>>> rtl/core/ebq_pkg.sv
// ----------------------------------------------------------------------------
// ebq_pkg
// Shared types, codes and constants of the encoder and button event queue.
// ----------------------------------------------------------------------------
package ebq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);

  localparam int unsigned CMD_W       = 3;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned ENC_GAP_W   = 16;
  localparam int unsigned BTN_GAP_W   = 20;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam logic [ENC_GAP_W-1:0] ENC_GAP_RST = 16'd10;
  localparam logic [BTN_GAP_W-1:0] BTN_GAP_RST = 20'd10000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ENC_A  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ENC_B  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SELECT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_POP    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_GAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BTN_GAP = 2'd1;

  // Event codes
  localparam logic [1:0] CODE_SELECT = 2'd0;
  localparam logic [1:0] CODE_BACK   = 2'd1;
  localparam logic [1:0] CODE_CW     = 2'd2;
  localparam logic [1:0] CODE_ACW    = 2'd3;

  // Phase bit masks: channel A drives bit 1, channel B bit 0
  localparam logic [1:0] MASK_A = 2'h2;
  localparam logic [1:0] MASK_B = 2'h1;

  typedef struct packed {
    logic       produced;
    logic [1:0] code;
  } ev_t;

  typedef struct packed {
    logic       event_valid;
    logic [1:0] event_code;
    logic       pushed;
    logic       dropped;
    logic       queue_empty;
  } res_t;

  // Count step for a phase transition (Gray-code quadrature table)
  function automatic logic signed [1:0] phase_delta(input logic [1:0] cur,
                                                     input logic [1:0] nxt);
    logic signed [1:0] d;
    d = 2'sd0;
    case ({cur, nxt})
      4'b0001: d = 2'sd1;
      4'b0010: d = -2'sd1;
      4'b0100: d = -2'sd1;
      4'b0111: d = 2'sd1;
      4'b1000: d = 2'sd1;
      4'b1011: d = -2'sd1;
      4'b1101: d = -2'sd1;
      4'b1110: d = 2'sd1;
      default: d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/ebq_event.sv
// ----------------------------------------------------------------------------
// ebq_event
// Debounce of the three sources (encoder, select, back), quadrature count and button edge events.
// ----------------------------------------------------------------------------
module ebq_event (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic [ebq_pkg::CMD_W-1:0]       cmd_i,
  input  logic [ebq_pkg::TIME_W-1:0]      time_i,
  input  logic [ebq_pkg::ENC_GAP_W-1:0]   enc_gap_i,
  input  logic [ebq_pkg::BTN_GAP_W-1:0]   btn_gap_i,
  output ebq_pkg::ev_t                    ev_o
);

  logic [1:0]                     phase_q, phase_d;
  logic signed [7:0]              cnt_q, cnt_d;
  logic [ebq_pkg::TIME_W-1:0]     enc_last_q, enc_last_d;
  logic                           sel_lvl_q, sel_lvl_d;
  logic [ebq_pkg::TIME_W-1:0]     sel_last_q, sel_last_d;
  logic                           back_lvl_q, back_lvl_d;
  logic [ebq_pkg::TIME_W-1:0]     back_last_q, back_last_d;

  logic [ebq_pkg::TIME_W-1:0]     enc_age, sel_age, back_age;
  logic                           enc_ok, sel_ok, back_ok;
  logic [1:0]                     mask, nxt;
  logic signed [1:0]              delta;
  logic signed [8:0]              sum;
  logic signed [7:0]              sat;

  // Wrapping age against each source's last accepted change
  assign enc_age  = time_i - enc_last_q;
  assign sel_age  = time_i - sel_last_q;
  assign back_age = time_i - back_last_q;
  assign enc_ok   = enc_age  >= {{(ebq_pkg::TIME_W-ebq_pkg::ENC_GAP_W){1'b0}}, enc_gap_i};
  assign sel_ok   = sel_age  >= {{(ebq_pkg::TIME_W-ebq_pkg::BTN_GAP_W){1'b0}}, btn_gap_i};
  assign back_ok  = back_age >= {{(ebq_pkg::TIME_W-ebq_pkg::BTN_GAP_W){1'b0}}, btn_gap_i};

  assign mask  = (cmd_i == ebq_pkg::CMD_ENC_A) ? ebq_pkg::MASK_A : ebq_pkg::MASK_B;
  assign nxt   = phase_q ^ mask;
  assign delta = ebq_pkg::phase_delta(phase_q, nxt);
  assign sum   = {cnt_q[7], cnt_q} + {{7{delta[1]}}, delta};

  // Clamp to the symmetric range
  always_comb begin
    if (sum > 9'sd127) begin
      sat = 8'sd127;
    end else if (sum < -9'sd127) begin
      sat = -8'sd127;
    end else begin
      sat = sum[7:0];
    end
  end

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    enc_last_d  = enc_last_q;
    sel_lvl_d   = sel_lvl_q;
    sel_last_d  = sel_last_q;
    back_lvl_d  = back_lvl_q;
    back_last_d = back_last_q;
    ev_o        = '0;
    if (fire_i) begin
      case (cmd_i)
        ebq_pkg::CMD_ENC_A, ebq_pkg::CMD_ENC_B: begin
          if (enc_ok) begin
            phase_d    = nxt;
            enc_last_d = time_i;
            cnt_d      = sat;
            // Detent reached: report direction and restart the count
            if (nxt == 2'b00 && sat != 8'sd0) begin
              ev_o.produced = 1'b1;
              ev_o.code     = sat[7] ? ebq_pkg::CODE_ACW : ebq_pkg::CODE_CW;
              cnt_d         = 8'sd0;
            end
          end
        end
        ebq_pkg::CMD_SELECT: begin
          if (sel_ok) begin
            sel_lvl_d  = ~sel_lvl_q;
            sel_last_d = time_i;
            if (!sel_lvl_q) begin
              ev_o.produced = 1'b1;
              ev_o.code     = ebq_pkg::CODE_SELECT;
            end
          end
        end
        ebq_pkg::CMD_BACK: begin
          if (back_ok) begin
            back_lvl_d  = ~back_lvl_q;
            back_last_d = time_i;
            if (back_lvl_q) begin
              ev_o.produced = 1'b1;
              ev_o.code     = ebq_pkg::CODE_BACK;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      cnt_q       <= '0;
      enc_last_q  <= '0;
      sel_lvl_q   <= 1'b0;
      sel_last_q  <= '0;
      back_lvl_q  <= 1'b0;
      back_last_q <= '0;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      enc_last_q  <= enc_last_d;
      sel_lvl_q   <= sel_lvl_d;
      sel_last_q  <= sel_last_d;
      back_lvl_q  <= back_lvl_d;
      back_last_q <= back_last_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != -8'sd128)
    else $error("encoder count left the clamped range");
  a_cnt_zero_at_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.produced && (cmd_i == ebq_pkg::CMD_ENC_A || cmd_i == ebq_pkg::CMD_ENC_B)
    |=> phase_q == 2'b00 && cnt_q == 8'sd0)
    else $error("direction event without return to rest");
  a_enc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(phase_q) && $stable(cnt_q))
    else $error("encoder state moved without an item");
`endif

endmodule

>>> rtl/core/ebq_queue.sv
// ----------------------------------------------------------------------------
// ebq_queue
// Ring queue of event codes with drop on full and pop on request.
// ----------------------------------------------------------------------------
module ebq_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic                       pop_i,
  input  ebq_pkg::ev_t               ev_i,
  output ebq_pkg::res_t              res_o
);

  logic [1:0]                  store_q [ebq_pkg::QUEUE_DEPTH];
  logic [ebq_pkg::QIDX_W-1:0]  rd_q, rd_d, wr_q, wr_d;
  logic [ebq_pkg::QIDX_W-1:0]  rd_inc, wr_inc;
  logic                        empty, full, do_push, do_pop;

  assign rd_inc = (rd_q == ebq_pkg::QIDX_W'(ebq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
  assign wr_inc = (wr_q == ebq_pkg::QIDX_W'(ebq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
  assign empty  = (rd_q == wr_q);
  assign full   = (wr_inc == rd_q);

  assign do_push = fire_i && ev_i.produced && !full;
  assign do_pop  = fire_i && pop_i && !empty;

  assign rd_d = do_pop  ? rd_inc : rd_q;
  assign wr_d = do_push ? wr_inc : wr_q;

  always_comb begin
    res_o             = '0;
    res_o.event_valid = do_pop;
    res_o.event_code  = do_pop ? store_q[rd_q] : 2'd0;
    res_o.pushed      = do_push;
    res_o.dropped     = fire_i && ev_i.produced && full;
    res_o.queue_empty = (rd_d == wr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= ev_i.code;
    end
  end

`ifndef SYNTHESIS
  a_push_pop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(do_push && do_pop))
    else $error("push and pop in one step");
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> rd_q != wr_q)
    else $error("queue empty after a push");
  a_pop_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> rd_q != $past(rd_q) && $stable(wr_q))
    else $error("pop did not advance the read index");
`endif

endmodule

>>> rtl/core/encoder_button_event_queue_core.sv
// ----------------------------------------------------------------------------
// encoder_button_event_queue_core
// Debounced quadrature encoder and button decoder feeding an event queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries a command and a microsecond
//   timestamp: encoder A or B change, select or back change, or a queue pop.
//   Each accepted transaction returns exactly one result on the output
//   channel (out_valid_o/out_ready_i): popped event and code, pushed,
//   dropped and the queue-empty flag after the step.
//   The config channel (cfg_valid_i/cfg_ready_o) writes the encoder debounce
//   (index 0, 16 bits) or button debounce (index 1, 20 bits); it is always
//   ready and should be used only while the block is idle.
//   A transaction is registered in the input register at acceptance; when
//   the result slot is free it is processed and its result is registered in
//   the output register, which raises out_valid_o. Throughput is one
//   transaction per cycle while out_ready_i stays high.
//   Reset clears the phase, count, timestamps, levels and queue indexes and
//   loads debounce defaults of 10 us and 10000 us.
//   When the receiver stalls, the result holds and one more transaction is
//   buffered in the input register before in_ready_o drops.
// ----------------------------------------------------------------------------
module encoder_button_event_queue_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ebq_pkg::CMD_W-1:0]           command_i,
  input  logic [ebq_pkg::TIME_W-1:0]          time_us_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                event_valid_o,
  output logic [1:0]                          event_code_o,
  output logic                                pushed_o,
  output logic                                dropped_o,
  output logic                                queue_empty_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ebq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ebq_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  logic                               in_vld_q;
  logic [ebq_pkg::CMD_W-1:0]          cmd_q;
  logic [ebq_pkg::TIME_W-1:0]         time_q;
  logic                               out_vld_q;
  ebq_pkg::res_t                      res_q;
  ebq_pkg::res_t                      res;
  ebq_pkg::ev_t                       ev;
  logic [ebq_pkg::ENC_GAP_W-1:0]      enc_gap_q;
  logic [ebq_pkg::BTN_GAP_W-1:0]      btn_gap_q;
  logic                               fire;
  logic                               pop;

  // Process the held transaction whenever the result slot frees up
  assign fire        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || fire;
  assign cfg_ready_o = 1'b1;
  assign pop         = (cmd_q == ebq_pkg::CMD_POP);

  ebq_event u_event (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .cmd_i     (cmd_q),
    .time_i    (time_q),
    .enc_gap_i (enc_gap_q),
    .btn_gap_i (btn_gap_q),
    .ev_o      (ev)
  );

  ebq_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .pop_i  (pop),
    .ev_i   (ev),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      enc_gap_q <= ebq_pkg::ENC_GAP_RST;
      btn_gap_q <= ebq_pkg::BTN_GAP_RST;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_index_i == ebq_pkg::CFG_ENC_GAP) begin
        enc_gap_q <= cfg_data_i[ebq_pkg::ENC_GAP_W-1:0];
      end
      if (cfg_valid_i && cfg_index_i == ebq_pkg::CFG_BTN_GAP) begin
        btn_gap_q <= cfg_data_i[ebq_pkg::BTN_GAP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      time_q <= time_us_i;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign event_valid_o = res_q.event_valid;
  assign event_code_o  = res_q.event_code;
  assign pushed_o      = res_q.pushed;
  assign dropped_o     = res_q.dropped;
  assign queue_empty_o = res_q.queue_empty;

`ifndef SYNTHESIS
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $countones({res_q.event_valid, res_q.pushed, res_q.dropped}) <= 1)
    else $error("result carries more than one of pop, push and drop");
  a_code_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_q.event_valid |-> res_q.event_code == 2'd0)
    else $error("event code without a popped event");
  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.pushed |-> !res_q.queue_empty)
    else $error("queue reported empty after a push");
`endif

endmodule

>>> bench/tb_encoder_button_event_queue_core.sv
// ----------------------------------------------------------------------------
// tb_encoder_button_event_queue_core
// Self-checking bench for the encoder and button event queue. A scripted
// opening covers reset state, unused commands, bounce rejection, both
// rotation directions, button press and release, timestamp wrap and popping
// to empty. Randomized rotation, button and pop traffic follows under several
// debounce settings. Every result is checked against a transaction-level model
// of the decoder and the queue, or for typed script rows a fixed expectation.
// ----------------------------------------------------------------------------
module tb_encoder_button_event_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ebq_pkg::CMD_W-1:0]     CMD_SPARE_LO  = 3'd5;
  localparam logic [ebq_pkg::CMD_W-1:0]     CMD_SPARE_MID = 3'd6;
  localparam logic [ebq_pkg::CMD_W-1:0]     CMD_SPARE_HI  = 3'd7;
  localparam logic [ebq_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO  = 2'd2;
  localparam logic [ebq_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI  = 2'd3;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 215;
  localparam int BURST_LEN       = 60;

  localparam ebq_pkg::res_t QUIET_EMPTY = '{event_valid: 1'b0, event_code: '0,
                                            pushed: 1'b0, dropped: 1'b0,
                                            queue_empty: 1'b1};

  // count step for each (current, next) phase pair
  localparam int PHASE_STEP [4][4] = '{'{ 0,  1, -1,  0},
                                       '{-1,  0,  0,  1},
                                       '{ 1,  0,  0, -1},
                                       '{ 0, -1,  1,  0}};

  typedef struct packed {
    logic [ebq_pkg::CMD_W-1:0]  cmd;
    logic [ebq_pkg::TIME_W-1:0] stamp;
    logic                       typed;
    ebq_pkg::res_t              want;
  } script_row_t;

  localparam int SCRIPT_LEN = 29;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ebq_pkg::CMD_POP,    32'd0,          1'b1, QUIET_EMPTY},
    '{CMD_SPARE_LO,        32'hFFFF_FFFF,  1'b1, QUIET_EMPTY},
    '{CMD_SPARE_HI,        32'd0,          1'b1, QUIET_EMPTY},
    '{ebq_pkg::CMD_ENC_A,  32'd5,          1'b1, QUIET_EMPTY},
    '{ebq_pkg::CMD_ENC_A,  32'd10,         1'b1, QUIET_EMPTY},
    '{ebq_pkg::CMD_ENC_B,  32'd20,         1'b0, '0},
    '{ebq_pkg::CMD_ENC_A,  32'd30,         1'b0, '0},
    '{ebq_pkg::CMD_ENC_B,  32'd40,         1'b0, '0},
    '{ebq_pkg::CMD_ENC_B,  32'd50,         1'b0, '0},
    '{ebq_pkg::CMD_ENC_B,  32'd60,         1'b0, '0},
    '{ebq_pkg::CMD_ENC_B,  32'd70,         1'b0, '0},
    '{ebq_pkg::CMD_ENC_A,  32'd80,         1'b0, '0},
    '{ebq_pkg::CMD_ENC_B,  32'd90,         1'b0, '0},
    '{ebq_pkg::CMD_ENC_A,  32'd100,        1'b0, '0},
    '{ebq_pkg::CMD_SELECT, 32'd9999,       1'b0, '0},
    '{ebq_pkg::CMD_SELECT, 32'd10000,      1'b0, '0},
    '{ebq_pkg::CMD_SELECT, 32'd10001,      1'b0, '0},
    '{ebq_pkg::CMD_SELECT, 32'd20000,      1'b0, '0},
    '{ebq_pkg::CMD_BACK,   32'd10000,      1'b0, '0},
    '{ebq_pkg::CMD_BACK,   32'd20000,      1'b0, '0},
    '{ebq_pkg::CMD_SELECT, 32'hFFFF_FFFF,  1'b0, '0},
    '{ebq_pkg::CMD_SELECT, 32'd9999,       1'b0, '0},
    '{CMD_SPARE_MID,       32'h5555_5555,  1'b0, '0},
    '{ebq_pkg::CMD_POP,    32'd0,          1'b0, '0},
    '{ebq_pkg::CMD_POP,    32'd0,          1'b0, '0},
    '{ebq_pkg::CMD_POP,    32'd0,          1'b0, '0},
    '{ebq_pkg::CMD_POP,    32'd0,          1'b0, '0},
    '{ebq_pkg::CMD_POP,    32'd0,          1'b0, '0},
    '{ebq_pkg::CMD_POP,    32'hAAAA_AAAA,  1'b1, QUIET_EMPTY}
  };

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic [ebq_pkg::CMD_W-1:0]      command_i   = '0;
  logic [ebq_pkg::TIME_W-1:0]     time_us_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           event_valid_o;
  logic [1:0]                     event_code_o;
  logic                           pushed_o;
  logic                           dropped_o;
  logic                           queue_empty_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [ebq_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [ebq_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // decoder and queue state as the block should hold it
  logic [1:0]                    dial_phase   = '0;
  int                            dial_count   = 0;
  logic [ebq_pkg::TIME_W-1:0]    dial_stamp   = '0;
  logic [ebq_pkg::TIME_W-1:0]    select_stamp = '0;
  logic [ebq_pkg::TIME_W-1:0]    back_stamp   = '0;
  logic                          select_down  = 1'b0;
  logic                          back_down    = 1'b0;
  logic [1:0]                    held_events [$];
  logic [ebq_pkg::ENC_GAP_W-1:0] enc_gap      = ebq_pkg::ENC_GAP_RST;
  logic [ebq_pkg::BTN_GAP_W-1:0] btn_gap      = ebq_pkg::BTN_GAP_RST;

  ebq_pkg::res_t awaited_reports [$];
  int            fault_count   = 0;
  int            send_idle_pct = 17;
  int            recv_idle_pct = 83;
  bit            spin_cw       = 1'b1;

  encoder_button_event_queue_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .time_us_i     (time_us_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_valid_o (event_valid_o),
    .event_code_o  (event_code_o),
    .pushed_o      (pushed_o),
    .dropped_o     (dropped_o),
    .queue_empty_o (queue_empty_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic ebq_pkg::res_t decode_step(input logic [ebq_pkg::CMD_W-1:0] cmd,
                                                input logic [ebq_pkg::TIME_W-1:0] stamp);
    ebq_pkg::res_t              r;
    logic                       made;
    logic [1:0]                 code;
    logic [1:0]                 nxt;
    logic [ebq_pkg::TIME_W-1:0] since;
    int                         c;
    r    = '0;
    made = 1'b0;
    code = ebq_pkg::CODE_SELECT;
    case (cmd)
      ebq_pkg::CMD_ENC_A, ebq_pkg::CMD_ENC_B: begin
        since = stamp - dial_stamp;
        if (since >= enc_gap) begin
          nxt = dial_phase ^ ((cmd == ebq_pkg::CMD_ENC_A) ? ebq_pkg::MASK_A
                                                           : ebq_pkg::MASK_B);
          c = dial_count + PHASE_STEP[dial_phase][nxt];
          if (c > 127) c = 127;
          if (c < -127) c = -127;
          // a full turn back to rest reports its direction and restarts the count
          if (nxt == '0 && c != 0) begin
            made = 1'b1;
            code = (c > 0) ? ebq_pkg::CODE_CW : ebq_pkg::CODE_ACW;
            c    = 0;
          end
          dial_count = c;
          dial_phase = nxt;
          dial_stamp = stamp;
        end
      end
      ebq_pkg::CMD_SELECT: begin
        since = stamp - select_stamp;
        if (since >= btn_gap) begin
          select_down  = ~select_down;
          made         = select_down;
          code         = ebq_pkg::CODE_SELECT;
          select_stamp = stamp;
        end
      end
      ebq_pkg::CMD_BACK: begin
        since = stamp - back_stamp;
        if (since >= btn_gap) begin
          back_down  = ~back_down;
          made       = ~back_down;
          code       = ebq_pkg::CODE_BACK;
          back_stamp = stamp;
        end
      end
      ebq_pkg::CMD_POP: begin
        if (held_events.size() != 0) begin
          r.event_valid = 1'b1;
          r.event_code  = held_events.pop_front();
        end
      end
      default: ;
    endcase
    if (made) begin
      if (held_events.size() == ebq_pkg::QUEUE_DEPTH - 1) begin
        r.dropped = 1'b1;
      end else begin
        held_events.push_back(code);
        r.pushed = 1'b1;
      end
    end
    r.queue_empty = (held_events.size() == 0);
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic drive_item(input logic [ebq_pkg::CMD_W-1:0] cmd,
                            input logic [ebq_pkg::TIME_W-1:0] stamp,
                            input logic typed, input ebq_pkg::res_t want);
    ebq_pkg::res_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    time_us_i  <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    r = decode_step(cmd, stamp);
    awaited_reports.push_back(typed ? want : r);
    @(negedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller drops it after the last write
  task automatic write_reg(input logic [ebq_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ebq_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ebq_pkg::CFG_ENC_GAP: enc_gap = data[ebq_pkg::ENC_GAP_W-1:0];
      ebq_pkg::CFG_BTN_GAP: btn_gap = data[ebq_pkg::BTN_GAP_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk_i) begin : check_results
    ebq_pkg::res_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_reports.size() == 0) begin
        $error("result transaction with nothing awaited");
        fault_count++;
      end else begin
        exp_r = awaited_reports.pop_front();
        if (event_valid_o !== exp_r.event_valid) begin
          $error("event_valid: expected %0d, got %0d", exp_r.event_valid, event_valid_o);
          fault_count++;
        end
        if (event_code_o !== exp_r.event_code) begin
          $error("event_code: expected %0d, got %0d", exp_r.event_code, event_code_o);
          fault_count++;
        end
        if (pushed_o !== exp_r.pushed) begin
          $error("pushed: expected %0d, got %0d", exp_r.pushed, pushed_o);
          fault_count++;
        end
        if (dropped_o !== exp_r.dropped) begin
          $error("dropped: expected %0d, got %0d", exp_r.dropped, dropped_o);
          fault_count++;
        end
        if (queue_empty_o !== exp_r.queue_empty) begin
          $error("queue_empty: expected %0d, got %0d", exp_r.queue_empty, queue_empty_o);
          fault_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [ebq_pkg::CMD_W-1:0]      cmd;
    logic [ebq_pkg::TIME_W-1:0]     stamp;
    logic [ebq_pkg::TIME_W-1:0]     now_us;
    logic [ebq_pkg::ENC_GAP_W-1:0]  enc_set;
    logic [ebq_pkg::BTN_GAP_W-1:0]  btn_set;
    logic [ebq_pkg::CFG_DATA_W-1:0] raw;
    int                             pop_pct;
    int                             pick;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      drive_item(SCRIPT[i].cmd, SCRIPT[i].stamp, SCRIPT[i].typed, SCRIPT[i].want);
    end
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin enc_set = ebq_pkg::ENC_GAP_RST; btn_set = ebq_pkg::BTN_GAP_RST; end
        1: begin enc_set = '0;                   btn_set = '0;                   end
        2: begin enc_set = '1;                   btn_set = '1;                   end
        3: begin
          enc_set = ebq_pkg::ENC_GAP_W'($urandom_range(200));
          btn_set = ebq_pkg::BTN_GAP_W'($urandom_range(5000));
        end
        4: begin
          enc_set = ebq_pkg::ENC_GAP_W'(1);
          btn_set = ebq_pkg::BTN_GAP_W'(1);
        end
        default: begin
          enc_set = ebq_pkg::ENC_GAP_W'($urandom);
          btn_set = ebq_pkg::BTN_GAP_W'($urandom);
        end
      endcase
      send_idle_pct = (p < 2) ? 17 : (p < 4) ? 83 : 0;
      recv_idle_pct = (p < 2) ? 83 : (p < 4) ? 17 : 0;

      // upper data bits are junk for the narrower register
      raw = ebq_pkg::CFG_DATA_W'($urandom);
      raw[ebq_pkg::ENC_GAP_W-1:0] = enc_set;
      write_reg(ebq_pkg::CFG_ENC_GAP, raw);
      write_reg(ebq_pkg::CFG_BTN_GAP, btn_set);
      if (p == 3) begin
        write_reg(CFG_SPARE_LO, ebq_pkg::CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, ebq_pkg::CFG_DATA_W'($urandom));
      end
      cfg_valid_i <= 1'b0;

      now_us = $urandom;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // alternate fill and drain bursts so the queue both overflows and empties
        pop_pct = ((k / BURST_LEN) % 2 == 0) ? 6 : 55;
        pick    = $urandom_range(99);
        if ($urandom_range(99) < pop_pct) begin
          cmd   = ebq_pkg::CMD_POP;
          stamp = $urandom;
        end else if (pick < 45) begin
          if ($urandom_range(9) == 0) spin_cw = ~spin_cw;
          // follow the quadrature sequence in the current direction
          cmd = ((dial_phase[1] == dial_phase[0]) == spin_cw) ? ebq_pkg::CMD_ENC_B
                                                             : ebq_pkg::CMD_ENC_A;
          if ($urandom_range(9) == 0) begin
            cmd = $urandom_range(1) ? ebq_pkg::CMD_ENC_A : ebq_pkg::CMD_ENC_B;
          end
          stamp  = now_us + (($urandom_range(6) == 0) ? $urandom_range(enc_gap)
                                                       : enc_gap + $urandom_range(20));
          now_us = stamp;
        end else if (pick < 85) begin
          cmd    = (pick < 65) ? ebq_pkg::CMD_SELECT : ebq_pkg::CMD_BACK;
          stamp  = now_us + (($urandom_range(6) == 0) ? $urandom_range(btn_gap)
                                                       : btn_gap + $urandom_range(500));
          now_us = stamp;
        end else begin
          cmd   = ebq_pkg::CMD_W'($urandom_range(7));
          stamp = $urandom;
        end
        drive_item(cmd, stamp, 1'b0, '0);
      end
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("encoder_button_event_queue_core regression: pass");
    end else begin
      $display("encoder_button_event_queue_core regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("encoder_button_event_queue_core regression: fail");
    $finish;
  end

endmodule

>>> encoder_button_event_queue_core.f
rtl/core/ebq_pkg.sv
rtl/core/ebq_event.sv
rtl/core/ebq_queue.sv
rtl/core/encoder_button_event_queue_core.sv
bench/tb_encoder_button_event_queue_core.sv
